// ===== rtl/fbd_pkg.sv =====
`default_nettype none

package fbd_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned INDEX_W    = 11;
    localparam int unsigned P_DEPTH    = 18;
    localparam int unsigned P_AW       = 5;
    localparam int unsigned SBOX_COUNT = 4;
    localparam int unsigned SBOX_DEPTH = 256;
    localparam int unsigned SBOX_AW    = 8;
    localparam int unsigned ROUND_W    = 5;

    localparam logic [INDEX_W-1:0] SBOX_BASE   = 11'd18;
    localparam logic [INDEX_W-1:0] TABLE_DEPTH = 11'd1042;

    localparam logic [P_AW-1:0]    P_FIRST     = 5'd17;
    localparam logic [P_AW-1:0]    P_LAST      = 5'd0;
    localparam logic [ROUND_W-1:0] ROUND_START = 5'd16;
    localparam logic [ROUND_W-1:0] ROUND_END   = 5'd1;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]  word_value;
        logic [WORD_W-1:0]  block_left;
        logic [WORD_W-1:0]  block_right;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] clear_left;
        logic [WORD_W-1:0] clear_right;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_ISSUE,
        ST_ROUND,
        ST_EXIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/fbd_ram.sv =====
`default_nettype none

module fbd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/feistel_block_decrypt.sv =====
// A decrypt request holds off new requests until its result has been loaded into the
// result register, which waits while a held result is stalled; a load request leaves
// the block ready for another request.
// Each of the 16 rounds passes through two states: ISSUE for the registered table reads and
// ROUND through the shared round function, with an ENTRY state before and an EXIT state after.
// Reset clears the sequencer and the result valid flag; the key table keeps its contents.
`default_nettype none

module feistel_block_decrypt (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire fbd_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output fbd_pkg::rsp_t      rsp
);

    fbd_pkg::state_t state_reg;
    fbd_pkg::state_t state_next;

    logic [fbd_pkg::ROUND_W-1:0] round_reg;
    logic [fbd_pkg::ROUND_W-1:0] round_next;
    logic [fbd_pkg::WORD_W-1:0]  cur_reg;
    logic [fbd_pkg::WORD_W-1:0]  cur_next;
    logic [fbd_pkg::WORD_W-1:0]  prev_reg;
    logic [fbd_pkg::WORD_W-1:0]  prev_next;
    fbd_pkg::rsp_t               rsp_reg;
    fbd_pkg::rsp_t               rsp_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;

    logic                          cmd_take;
    logic                          out_free;
    logic                          load_rsp;
    logic [fbd_pkg::INDEX_W-1:0]   sbox_off;
    logic                          p_we;
    logic [fbd_pkg::P_AW-1:0]      p_raddr;
    logic [fbd_pkg::WORD_W-1:0]    p_rdata;
    logic [fbd_pkg::SBOX_COUNT-1:0] s_we;
    logic [fbd_pkg::SBOX_AW-1:0]   s_raddr [fbd_pkg::SBOX_COUNT];
    logic [fbd_pkg::WORD_W-1:0]    s_rdata [fbd_pkg::SBOX_COUNT];
    logic [fbd_pkg::WORD_W-1:0]    round_f;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign sbox_off = cmd.word_index - fbd_pkg::SBOX_BASE;

    fbd_ram #(
        .WIDTH(fbd_pkg::WORD_W),
        .DEPTH(fbd_pkg::P_DEPTH)
    ) u_pram (
        .clk  (clk),
        .we   (p_we),
        .waddr(cmd.word_index[fbd_pkg::P_AW-1:0]),
        .wdata(cmd.word_value),
        .raddr(p_raddr),
        .rdata(p_rdata)
    );

    for (genvar k = 0; k < fbd_pkg::SBOX_COUNT; k++)
    begin : g_sbox
        assign s_raddr[k] = cur_reg[fbd_pkg::SBOX_AW*(fbd_pkg::SBOX_COUNT-1-k)
                                    +: fbd_pkg::SBOX_AW];

        fbd_ram #(
            .WIDTH(fbd_pkg::WORD_W),
            .DEPTH(fbd_pkg::SBOX_DEPTH)
        ) u_sram (
            .clk  (clk),
            .we   (s_we[k]),
            .waddr(sbox_off[fbd_pkg::SBOX_AW-1:0]),
            .wdata(cmd.word_value),
            .raddr(s_raddr[k]),
            .rdata(s_rdata[k])
        );
    end

    assign round_f = ((s_rdata[0] + s_rdata[1]) ^ s_rdata[2]) + s_rdata[3];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbd_pkg::ST_IDLE:
            begin
                if (cmd_take && cmd.mode == fbd_pkg::MODE_DECRYPT)
                begin
                    state_next = fbd_pkg::ST_ENTRY;
                end
            end
            fbd_pkg::ST_ENTRY:
            begin
                state_next = fbd_pkg::ST_ISSUE;
            end
            fbd_pkg::ST_ISSUE:
            begin
                state_next = fbd_pkg::ST_ROUND;
            end
            fbd_pkg::ST_ROUND:
            begin
                if (round_reg == fbd_pkg::ROUND_END)
                begin
                    state_next = fbd_pkg::ST_EXIT;
                end
                else
                begin
                    state_next = fbd_pkg::ST_ISSUE;
                end
            end
            fbd_pkg::ST_EXIT:
            begin
                if (out_free)
                begin
                    state_next = fbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        p_raddr   = fbd_pkg::P_FIRST;
        p_we      = 1'b0;
        s_we      = '0;
        load_rsp  = 1'b0;
        case (state_reg)
            fbd_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_take && cmd.mode == fbd_pkg::MODE_LOAD)
                begin
                    if (cmd.word_index < fbd_pkg::SBOX_BASE)
                    begin
                        p_we = 1'b1;
                    end
                    else if (cmd.word_index < fbd_pkg::TABLE_DEPTH)
                    begin
                        s_we[sbox_off[fbd_pkg::SBOX_AW+1:fbd_pkg::SBOX_AW]] = 1'b1;
                    end
                end
            end
            fbd_pkg::ST_ENTRY:
            begin
                p_raddr = fbd_pkg::P_FIRST;
            end
            fbd_pkg::ST_ISSUE:
            begin
                p_raddr = round_reg;
            end
            fbd_pkg::ST_ROUND:
            begin
                p_raddr = fbd_pkg::P_LAST;
            end
            fbd_pkg::ST_EXIT:
            begin
                p_raddr  = fbd_pkg::P_LAST;
                load_rsp = out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        round_next     = round_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            fbd_pkg::ST_IDLE:
            begin
                round_next = fbd_pkg::ROUND_START;
                cur_next   = cmd.block_left;
                prev_next  = cmd.block_right;
            end
            fbd_pkg::ST_ENTRY:
            begin
                cur_next = cur_reg ^ p_rdata;
            end
            fbd_pkg::ST_ROUND:
            begin
                cur_next   = prev_reg ^ round_f ^ p_rdata;
                prev_next  = cur_reg;
                round_next = round_reg - 1'b1;
            end
            default:
            begin
                round_next = round_reg;
            end
        endcase
        if (load_rsp)
        begin
            rsp_next.clear_left  = prev_reg ^ p_rdata;
            rsp_next.clear_right = cur_reg;
            rsp_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbd_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/fbd_checker.sv =====
`default_nettype none

module fbd_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          cmd_valid,
    input wire logic          cmd_stall,
    input wire fbd_pkg::cmd_t cmd,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire fbd_pkg::rsp_t rsp
);

    // A stalled result must hold until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    // A decrypt request keeps the block busy in the following cycle.
    a_decrypt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.mode == fbd_pkg::MODE_DECRYPT |=> cmd_stall)
        else $error("decrypt request did not make the block busy");

    // A load request leaves the block ready for a new request in the following cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.mode == fbd_pkg::MODE_LOAD |=> !cmd_stall)
        else $error("load request left the block busy");

    // A new result only comes out of a running decryption.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_stall))
        else $error("result appeared without a decryption in progress");

endmodule

bind feistel_block_decrypt fbd_checker u_fbd_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;

    import fbd_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int KEY_WORDS    = int'(TABLE_DEPTH);
    localparam int SBOX0_AT     = int'(SBOX_BASE);
    localparam int SBOX_STRIDE  = int'(SBOX_DEPTH);
    localparam int RANDOM_ITEMS = 640;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 600000;

    class decrypt_scoreboard;
        logic [WORD_W-1:0] key_words [KEY_WORDS];
        rsp_t              expected_clear [$];
        int                mismatches;

        function new();
            mismatches = 0;
            foreach (key_words[i])
            begin
                key_words[i] = '0;
            end
        endfunction

        task report(input string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endtask

        function logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] x);
            logic [WORD_W-1:0] v;
            v = key_words[SBOX0_AT + int'(x[31:24])];
            v = v + key_words[SBOX0_AT + SBOX_STRIDE + int'(x[23:16])];
            v = v ^ key_words[SBOX0_AT + 2 * SBOX_STRIDE + int'(x[15:8])];
            v = v + key_words[SBOX0_AT + 3 * SBOX_STRIDE + int'(x[7:0])];
            return v;
        endfunction

        function rsp_t predict_clear(input cmd_t c);
            logic [WORD_W-1:0] cur;
            logic [WORD_W-1:0] prev;
            logic [WORD_W-1:0] tmp;
            rsp_t              r;
            cur  = c.block_left ^ key_words[P_FIRST];
            prev = c.block_right;
            for (int k = int'(ROUND_START); k >= int'(ROUND_END); k--)
            begin
                tmp  = prev ^ round_mix(cur) ^ key_words[k];
                prev = cur;
                cur  = tmp;
            end
            prev = prev ^ key_words[P_LAST];
            r.clear_left  = prev;
            r.clear_right = cur;
            return r;
        endfunction

        task note_request(input cmd_t c);
            if (c.mode == MODE_DECRYPT)
            begin
                expected_clear.push_back(predict_clear(c));
            end
            else if (c.word_index < TABLE_DEPTH)
            begin
                key_words[c.word_index] = c.word_value;
            end
        endtask

        task check_result(input rsp_t got);
            rsp_t want;
            if (expected_clear.size() == 0)
            begin
                report($sformatf("result %h arrived with no decrypt pending", got));
                return;
            end
            want = expected_clear.pop_front();
            if (got.clear_left !== want.clear_left)
            begin
                report($sformatf("clear_left got %h want %h", got.clear_left, want.clear_left));
            end
            if (got.clear_right !== want.clear_right)
            begin
                report($sformatf("clear_right got %h want %h",
                                 got.clear_right, want.clear_right));
            end
        endtask

        function int pending();
            return expected_clear.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    cmd_t cmd       = '0;
    logic rsp_stall = 1'b0;
    logic cmd_stall;
    logic rsp_valid;
    rsp_t rsp;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    decrypt_scoreboard sb = new();

    feistel_block_decrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #CLK_LOW clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            sb.note_request(cmd);
        end
        if (rsp_valid && !rsp_stall)
        begin
            sb.check_result(rsp);
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * (CLK_HIGH + CLK_LOW));
        $display("tb: FAIL");
        $finish;
    end

    function logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_word(input int idx, input logic [WORD_W-1:0] val);
        cmd_t c;
        c.mode        = MODE_LOAD;
        c.word_index  = idx[INDEX_W-1:0];
        c.word_value  = val;
        c.block_left  = $urandom();
        c.block_right = $urandom();
        send_cmd(c);
    endtask

    task automatic send_decrypt(input logic [WORD_W-1:0] left, input logic [WORD_W-1:0] right);
        cmd_t        c;
        logic [31:0] noise;
        noise         = $urandom();
        c.mode        = MODE_DECRYPT;
        c.word_index  = noise[INDEX_W-1:0];
        c.word_value  = $urandom();
        c.block_left  = left;
        c.block_right = right;
        send_cmd(c);
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            send_decrypt(pick_word(), pick_word());
        end
        else if (pick < 65)
        begin
            load_word($urandom_range(P_DEPTH - 1), pick_word());
        end
        else if (pick < 95)
        begin
            load_word($urandom_range(KEY_WORDS - 1), pick_word());
        end
        else
        begin
            load_word($urandom_range(2047, KEY_WORDS), pick_word());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        stall_pct     = 48;

        // The whole key table is written before any decrypt reads it.
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            load_word(i, pick_word());
        end

        send_decrypt('0, '0);
        send_decrypt('1, '1);
        send_decrypt('0, '1);
        send_decrypt('1, '0);
        send_decrypt(32'h8000_0001, 32'h0123_4567);
        load_word(KEY_WORDS, '1);
        load_word(2047, '0);
        load_word(1536, 32'hA5A5_5A5A);
        send_decrypt(32'h0000_0001, 32'h8000_0000);
        load_word(int'(P_FIRST), '0);
        load_word(int'(P_LAST), '1);
        load_word(SBOX0_AT, '1);
        load_word(KEY_WORDS - 1, '1);
        send_decrypt('0, '0);
        send_decrypt('1, '1);
        load_word(int'(P_FIRST), '1);
        load_word(int'(P_LAST), '0);
        send_decrypt($urandom(), $urandom());

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    stall_pct     = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    stall_pct     = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            repeat (RANDOM_ITEMS / 3) random_request();
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/fbd_pkg.sv
rtl/fbd_ram.sv
rtl/feistel_block_decrypt.sv
rtl/fbd_checker.sv
test/tb.sv
